// ----- design/csfd_pkg.sv -----
package csfd_pkg;

   // Frame geometry
   localparam int FRAME_BYTES = 20;
   localparam int FILL_W      = $clog2(FRAME_BYTES + 1);

   // Byte positions inside a full window, oldest byte at position 0
   localparam int POS_SYNC0 = 0;
   localparam int POS_SYNC1 = 1;
   localparam int POS_TYPE  = 2;
   localparam int POS_IDE   = 3;
   localparam int POS_RTR   = 4;
   localparam int POS_ID    = 5;
   localparam int POS_DLC   = 9;
   localparam int POS_DATA  = 10;
   localparam int POS_CSUM  = 19;

   // Checksum covers positions POS_TYPE up to POS_CSUM-1
   localparam logic [FILL_W-1:0] CSUM_ENTRY_FILL =
      FILL_W'(FRAME_BYTES - POS_TYPE);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(FRAME_BYTES);

   localparam logic [7:0] SYNC0_BYTE = 8'hAA;
   localparam logic [7:0] SYNC1_BYTE = 8'h55;
   localparam logic [7:0] TYPE_CAN   = 8'h01;
   localparam logic [7:0] MARK_ONE   = 8'h01;
   localparam logic [7:0] MARK_TWO   = 8'h02;
   localparam logic [7:0] MAX_DLC    = 8'd8;

   typedef logic [FRAME_BYTES-1:0][7:0] window_type;

   typedef struct packed {
      logic        extended_id;
      logic        remote_request;
      logic [31:0] identifier;
      logic [3:0]  length_code;
      logic [31:0] payload_low;
      logic [31:0] payload_high;
   } msg_type;

endpackage

// ----- design/can_serial_frame_deframer.sv -----
// Serial CAN frame deframer. One received byte is taken per req transaction
// and shifted into a 20-byte window; once the window is full it is checked
// in the cycle after each byte for sync AA 55, type 01, IDE/RTR markers 01
// or 02, DLC at most 8 and an 8-bit additive checksum of bytes 2..18 equal
// to byte 19. A good frame produces one rsp transaction with the decoded
// CAN message and empties the window; otherwise the window slides by one
// byte. The checksum is kept as a running sum, so the block takes one byte
// per clock unless stalled; the rsp transaction comes from a register.
// Input stalls only while a good frame waits for a full result register.
module can_serial_frame_deframer
   import csfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_extended_id,
   output logic        rsp_remote_request,
   output logic [31:0] rsp_identifier,
   output logic [3:0]  rsp_length_code,
   output logic [31:0] rsp_payload_low,
   output logic [31:0] rsp_payload_high
);

   window_type window;
   logic [7:0] window_sum;
   logic       pending, frame_ok, slot_free, retire, clear, accept;
   msg_type    msg, msg_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   csfd_window u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .retire     (retire),
      .clear      (clear),
      .window     (window),
      .window_sum (window_sum),
      .pending    (pending)
   );

   csfd_check u_check (
      .window     (window),
      .window_sum (window_sum),
      .frame_ok   (frame_ok),
      .msg        (msg)
   );

   // Handshake: a pending good frame needs a free result slot
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign retire    = pending && (!frame_ok || slot_free);
   assign clear     = retire && frame_ok;
   assign req_ready = !pending || retire;
   assign accept    = req_valid && req_ready;

   // Result register
   always_comb begin
      if (clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         msg_ff <= msg;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_extended_id    = msg_ff.extended_id;
   assign rsp_remote_request = msg_ff.remote_request;
   assign rsp_identifier     = msg_ff.identifier;
   assign rsp_length_code    = msg_ff.length_code;
   assign rsp_payload_low    = msg_ff.payload_low;
   assign rsp_payload_high   = msg_ff.payload_high;

endmodule

// ----- design/csfd_window.sv -----
module csfd_window
   import csfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       retire,
   input  logic       clear,
   output window_type window,
   output logic [7:0] window_sum,
   output logic       pending
);

   window_type        win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_base;
   logic [7:0]        sum_ff, sum_in, sum_base, sum_drop, sum_add;
   logic              pending_ff, pending_in;

   // Shift the new byte in at the top, oldest byte leaves at position 0
   always_comb begin
      win_in = win_ff;
      if (accept) begin
         win_in = {rx_byte, win_ff[FRAME_BYTES-1:1]};
      end
   end

   // Fill count and running checksum of the valid bytes in the checksum span
   always_comb begin
      fill_base = clear ? '0 : fill_ff;
      sum_base  = clear ? '0 : sum_ff;
      sum_drop  = (fill_base >= CSUM_ENTRY_FILL) ? win_ff[POS_TYPE] : 8'd0;
      sum_add   = (fill_base != '0) ? win_ff[POS_CSUM] : 8'd0;
      fill_in   = fill_base;
      sum_in    = sum_base;
      if (accept) begin
         fill_in = (fill_base < FULL_FILL) ? fill_base + 1'b1 : FULL_FILL;
         sum_in  = sum_base - sum_drop + sum_add;
      end
   end

   // A check is pending once the window is full after a new byte
   always_comb begin
      if (accept) begin
         pending_in = (fill_in == FULL_FILL);
      end else if (retire) begin
         pending_in = 1'b0;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff    <= '0;
         sum_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         pending_ff <= pending_in;
      end
   end

   assign window     = win_ff;
   assign window_sum = sum_ff;
   assign pending    = pending_ff;

endmodule

// ----- design/csfd_check.sv -----
module csfd_check
   import csfd_pkg::*;
(
   input  window_type window,
   input  logic [7:0] window_sum,
   output logic       frame_ok,
   output msg_type    msg
);

   logic [7:0] dlc;
   logic [7:0] data_byte [8];

   // Frame checks
   always_comb begin
      dlc      = window[POS_DLC];
      frame_ok = (window[POS_SYNC0] == SYNC0_BYTE)
              && (window[POS_SYNC1] == SYNC1_BYTE)
              && (window_sum == window[POS_CSUM])
              && (window[POS_TYPE] == TYPE_CAN)
              && ((window[POS_IDE] == MARK_ONE) || (window[POS_IDE] == MARK_TWO))
              && ((window[POS_RTR] == MARK_ONE) || (window[POS_RTR] == MARK_TWO))
              && (dlc <= MAX_DLC);
   end

   // Data bytes past the length read as zero
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         data_byte[k] = (8'(k) < dlc) ? window[POS_DATA + k] : 8'd0;
      end
   end

   // Message fields
   always_comb begin
      msg.extended_id    = (window[POS_IDE] == MARK_TWO);
      msg.remote_request = (window[POS_RTR] == MARK_TWO);
      msg.identifier     = {window[POS_ID+3], window[POS_ID+2],
                            window[POS_ID+1], window[POS_ID]};
      msg.length_code    = dlc[3:0];
      msg.payload_low    = {data_byte[3], data_byte[2], data_byte[1], data_byte[0]};
      msg.payload_high   = {data_byte[7], data_byte[6], data_byte[5], data_byte[4]};
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
   import csfd_pkg::*;
();

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 4;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int RANDOM_BYTES   = 900;
   localparam int PAUSE_EVERY    = 8;
   localparam int DRAIN_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int DIR_COUNT      = 25;

   // Ways a generated frame can be spoiled
   typedef enum int {
      FLAW_NONE,
      FLAW_SYNC,
      FLAW_TYPE,
      FLAW_MARKER,
      FLAW_DLC,
      FLAW_CSUM,
      FLAW_CUT
   } frame_flaw_type;

   // One directed byte, with a hand-written message where one must come out
   typedef struct packed {
      logic [7:0] rx;
      logic       has_golden;
      msg_type    golden;
   } dir_row_type;

   // Stray sync byte first, so the first full window fails and slides.
   // The frame is extended + remote, DLC 3, with filler beyond the length.
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{SYNC0_BYTE, 1'b0, '0},
      '{SYNC0_BYTE, 1'b0, '0},
      '{SYNC1_BYTE, 1'b0, '0},
      '{TYPE_CAN,   1'b0, '0},
      '{MARK_TWO,   1'b0, '0},
      '{MARK_TWO,   1'b0, '0},
      '{8'h00,      1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{8'h12,      1'b0, '0},
      '{8'h80,      1'b0, '0},
      '{8'h03,      1'b0, '0},
      '{8'h11,      1'b0, '0},
      '{8'h22,      1'b0, '0},
      '{8'h33,      1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{8'h00,      1'b0, '0},
      '{8'hFA,      1'b1, '{extended_id: 1'b1, remote_request: 1'b1,
                           identifier: 32'h8012_FF00, length_code: 4'd3,
                           payload_low: 32'h0033_2211, payload_high: 32'h0}},
      '{8'h00,      1'b0, '0},
      '{8'hFF,      1'b0, '0},
      '{SYNC1_BYTE, 1'b0, '0},
      '{SYNC0_BYTE, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_extended_id;
   logic        rsp_remote_request;
   logic [31:0] rsp_identifier;
   logic [3:0]  rsp_length_code;
   logic [31:0] rsp_payload_low;
   logic [31:0] rsp_payload_high;

   // Deframer mirror and the messages it still expects to see
   logic [7:0]  win_bytes [FRAME_BYTES];
   int          win_fill = 0;
   msg_type     frame_q [$];

   int          error_count   = 0;
   int          bytes_sent    = 0;
   int          msgs_expected = 0;
   int          msgs_checked  = 0;
   int          flawed_frames = 0;
   int          pauses        = 0;
   bit          no_idle       = 1'b0;

   can_serial_frame_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_extended_id    (rsp_extended_id),
      .rsp_remote_request (rsp_remote_request),
      .rsp_identifier     (rsp_identifier),
      .rsp_length_code    (rsp_length_code),
      .rsp_payload_low    (rsp_payload_low),
      .rsp_payload_high   (rsp_payload_high)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // Shift one byte into the window; returns 1 with the message on a good frame
   function automatic bit deframe_byte(input logic [7:0] b, output msg_type m);
      logic [7:0] sum;
      int         dlc;
      m = '0;
      if (win_fill < FRAME_BYTES) begin
         win_bytes[win_fill] = b;
         win_fill++;
      end else begin
         for (int i = 0; i < FRAME_BYTES - 1; i++)
            win_bytes[i] = win_bytes[i + 1];
         win_bytes[FRAME_BYTES - 1] = b;
      end
      if (win_fill < FRAME_BYTES)
         return 1'b0;

      sum = 8'h00;
      for (int i = POS_TYPE; i < POS_CSUM; i++)
         sum = sum + win_bytes[i];

      if (win_bytes[POS_SYNC0] != SYNC0_BYTE || win_bytes[POS_SYNC1] != SYNC1_BYTE)
         return 1'b0;
      if (sum != win_bytes[POS_CSUM])
         return 1'b0;
      if (win_bytes[POS_TYPE] != TYPE_CAN)
         return 1'b0;
      if (!(win_bytes[POS_IDE] == MARK_ONE || win_bytes[POS_IDE] == MARK_TWO))
         return 1'b0;
      if (!(win_bytes[POS_RTR] == MARK_ONE || win_bytes[POS_RTR] == MARK_TWO))
         return 1'b0;
      if (win_bytes[POS_DLC] > MAX_DLC)
         return 1'b0;

      dlc = win_bytes[POS_DLC];
      m.extended_id    = (win_bytes[POS_IDE] == MARK_TWO);
      m.remote_request = (win_bytes[POS_RTR] == MARK_TWO);
      m.identifier     = {win_bytes[POS_ID + 3], win_bytes[POS_ID + 2],
                          win_bytes[POS_ID + 1], win_bytes[POS_ID]};
      m.length_code    = 4'(dlc);
      // data past the length reads as zero
      for (int k = 0; k < 8; k++) begin
         if (k < dlc) begin
            if (k < 4)
               m.payload_low[8 * k +: 8] = win_bytes[POS_DATA + k];
            else
               m.payload_high[8 * (k - 4) +: 8] = win_bytes[POS_DATA + k];
         end
      end
      win_fill = 0;
      return 1'b1;
   endfunction

   // Random frame, correct unless a flaw is asked for
   function automatic void build_frame(input frame_flaw_type flaw,
                                       output logic [7:0] fb [FRAME_BYTES]);
      logic [7:0] sum;
      logic [7:0] v;
      int         pos;
      fb[POS_SYNC0] = SYNC0_BYTE;
      fb[POS_SYNC1] = SYNC1_BYTE;
      fb[POS_TYPE]  = TYPE_CAN;
      fb[POS_IDE]   = $urandom_range(0, 1) ? MARK_TWO : MARK_ONE;
      fb[POS_RTR]   = $urandom_range(0, 1) ? MARK_TWO : MARK_ONE;
      // identifier extremes now and then
      case ($urandom_range(0, 7))
         0: v = 8'h00;
         1: v = 8'hFF;
         default: v = 8'h00;
      endcase
      for (int i = 0; i < 4; i++)
         fb[POS_ID + i] = (v == 8'h00 && $urandom_range(0, 7) > 1) ?
                          8'($urandom_range(0, 255)) : v;
      fb[POS_DLC] = 8'($urandom_range(0, 8));
      for (int i = POS_DATA; i < POS_CSUM; i++)
         fb[i] = 8'($urandom_range(0, 255));

      case (flaw)
         FLAW_SYNC: begin
            pos = $urandom_range(POS_SYNC0, POS_SYNC1);
            fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
         end
         FLAW_TYPE: fb[POS_TYPE] = TYPE_CAN ^ 8'($urandom_range(1, 255));
         FLAW_MARKER: begin
            // anything but the two legal markers
            v = 8'($urandom_range(0, 253));
            if (v != 8'h00)
               v = v + 8'd2;
            pos = $urandom_range(POS_IDE, POS_RTR);
            fb[pos] = v;
         end
         FLAW_DLC: fb[POS_DLC] = 8'($urandom_range(9, 255));
         default: ;
      endcase

      sum = 8'h00;
      for (int i = POS_TYPE; i < POS_CSUM; i++)
         sum = sum + fb[i];
      fb[POS_CSUM] = sum;
      if (flaw == FLAW_CSUM)
         fb[POS_CSUM] = sum ^ 8'($urandom_range(1, 255));
   endfunction

   // Drive one req transaction and record what it should produce
   task automatic send_byte(input logic [7:0] b, input bit use_golden,
                            input msg_type golden);
      int      gap;
      bit      found;
      msg_type m;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;

      found = deframe_byte(b, m);
      if (use_golden) begin
         if (!found)
            report_mismatch($sformatf("byte %h should close a frame", b));
         frame_q.push_back(golden);
         msgs_expected++;
      end else if (found) begin
         frame_q.push_back(m);
         msgs_expected++;
      end
   endtask

   // Compare one rsp transaction with the oldest expected message
   task automatic check_message();
      msg_type want;
      if (frame_q.size() == 0) begin
         report_mismatch($sformatf("unexpected message, identifier %h", rsp_identifier));
         return;
      end
      want = frame_q.pop_front();
      if (rsp_extended_id !== want.extended_id)
         report_mismatch($sformatf("extended_id got %b expected %b",
                                   rsp_extended_id, want.extended_id));
      if (rsp_remote_request !== want.remote_request)
         report_mismatch($sformatf("remote_request got %b expected %b",
                                   rsp_remote_request, want.remote_request));
      if (rsp_identifier !== want.identifier)
         report_mismatch($sformatf("identifier got %h expected %h",
                                   rsp_identifier, want.identifier));
      if (rsp_length_code !== want.length_code)
         report_mismatch($sformatf("length_code got %h expected %h",
                                   rsp_length_code, want.length_code));
      if (rsp_payload_low !== want.payload_low)
         report_mismatch($sformatf("payload_low got %h expected %h",
                                   rsp_payload_low, want.payload_low));
      if (rsp_payload_high !== want.payload_high)
         report_mismatch($sformatf("payload_high got %h expected %h",
                                   rsp_payload_high, want.payload_high));
      msgs_checked++;
   endtask

   // Result side: random stall per transaction, then wait for valid
   initial begin
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_message();
      end
   end

   // Stimulus and end of run
   initial begin
      logic [7:0]     fb [FRAME_BYTES];
      frame_flaw_type flaw;
      int             noise;
      int             nbytes;
      int             frame_no;
      int             random_start;
      int             drain;
      int             r;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed bytes
      for (int i = 0; i < DIR_COUNT; i++)
         send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].has_golden, DIR_ROWS[i].golden);

      // random frames with noise in between
      random_start = bytes_sent;
      frame_no = 0;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         no_idle = ($urandom_range(0, 4) == 0);

         noise = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         for (int i = 0; i < noise; i++) begin
            case ($urandom_range(0, 5))
               0: send_byte(SYNC0_BYTE, 1'b0, '0);
               1: send_byte(SYNC1_BYTE, 1'b0, '0);
               default: send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            endcase
         end

         r = $urandom_range(0, 99);
         if (r < 75)      flaw = FLAW_NONE;
         else if (r < 80) flaw = FLAW_SYNC;
         else if (r < 84) flaw = FLAW_TYPE;
         else if (r < 88) flaw = FLAW_MARKER;
         else if (r < 92) flaw = FLAW_DLC;
         else if (r < 96) flaw = FLAW_CSUM;
         else             flaw = FLAW_CUT;
         if (flaw != FLAW_NONE)
            flawed_frames++;

         build_frame(flaw, fb);
         nbytes = (flaw == FLAW_CUT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
         for (int i = 0; i < nbytes; i++)
            send_byte(fb[i], 1'b0, '0);
         frame_no++;

         // hold the input until the output side has caught up
         if (frame_no % PAUSE_EVERY == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (frame_q.size() != 0) @(posedge clock);
            pauses++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      drain = 0;
      while (frame_q.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (frame_q.size() != 0)
         report_mismatch($sformatf("%0d expected messages never came out", frame_q.size()));
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d received bytes (%0d directed) in %0d random frames,",
               bytes_sent, DIR_COUNT, frame_no);
      $display("%0d of them spoiled or cut; %0d CAN messages checked, %0d drain pauses.",
               flawed_frames, msgs_checked, pauses);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
